### rtl/isci_pkg.sv
// Shared types and constants for the interval set coalescing insert block.
package isci_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int KEY_W         = 64;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_REVERSED  = 3'd1,
        ST_OVER_NEXT = 3'd2,
        ST_OVER_PREV = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_MERGE_BOTH,
        OP_MERGE_LEFT,
        OP_MERGE_RIGHT,
        OP_INSERT,
        OP_ROTATE
    } op_t;

    typedef struct packed {
        logic [KEY_W-1:0] start;
        logic [KEY_W-1:0] stop;
    } entry_t;

    typedef struct packed {
        logic over_next;
        logic over_prev;
        logic join_r;
        logic join_l;
    } flag_t;

endpackage

### rtl/isci_cell.sv
// One table slot: holds a range, compares it with the incoming range, shifts with its neighbors.
module isci_cell (
    input  logic                       aclk,
    input  logic                       cmp_en,
    input  logic [isci_pkg::KEY_W-1:0] cmp_b,
    input  logic [isci_pkg::KEY_W-1:0] cmp_e,
    input  logic [isci_pkg::KEY_W-1:0] upd_b,
    input  logic [isci_pkg::KEY_W-1:0] upd_e,
    input  isci_pkg::op_t              op,
    input  logic                       occ,
    input  logic                       occ_next,
    input  logic                       le_prev,
    input  logic                       le_next,
    input  isci_pkg::entry_t           left_ent,
    input  isci_pkg::entry_t           right_ent,
    input  isci_pkg::entry_t           head_ent,
    output isci_pkg::entry_t           ent,
    output logic                       le,
    output isci_pkg::flag_t            flags
);

    isci_pkg::entry_t ent_reg;
    logic le_reg;
    logic gt_e_reg;
    logic eq_e_reg;
    logic gt_b_reg;
    logic eq_b_reg;
    logic is_next;
    logic is_prev;
    logic at_pos;

    assign ent     = ent_reg;
    assign le      = le_reg;
    assign at_pos  = !le_reg && le_prev;
    assign is_next = occ && at_pos;
    assign is_prev = le_reg && !le_next;

    assign flags.over_next = is_next && gt_e_reg;
    assign flags.join_r    = is_next && eq_e_reg;
    assign flags.over_prev = is_prev && gt_b_reg;
    assign flags.join_l    = is_prev && eq_b_reg;

    always_ff @(posedge aclk) begin
        if (cmp_en) begin
            le_reg   <= occ && (ent_reg.start <= cmp_b);
            gt_e_reg <= cmp_e > ent_reg.start;
            eq_e_reg <= cmp_e == ent_reg.start;
            gt_b_reg <= ent_reg.stop > cmp_b;
            eq_b_reg <= ent_reg.stop == cmp_b;
        end
        case (op)
            isci_pkg::OP_MERGE_BOTH: begin
                if (is_prev) begin
                    ent_reg.stop <= right_ent.stop;
                end else if (!le_reg) begin
                    ent_reg <= right_ent;
                end
            end
            isci_pkg::OP_MERGE_LEFT: begin
                if (is_prev) begin
                    ent_reg.stop <= upd_e;
                end
            end
            isci_pkg::OP_MERGE_RIGHT: begin
                if (is_next) begin
                    ent_reg.start <= upd_b;
                end
            end
            isci_pkg::OP_INSERT: begin
                if (at_pos) begin
                    ent_reg.start <= upd_b;
                    ent_reg.stop  <= upd_e;
                end else if (!le_reg) begin
                    ent_reg <= left_ent;
                end
            end
            isci_pkg::OP_ROTATE: begin
                if (occ && !occ_next) begin
                    ent_reg <= head_ent;
                end else begin
                    ent_reg <= right_ent;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

### rtl/interval_set_coalescing_insert_top.sv
// Top level of the interval set coalescing insert block: control, totals and the cell chain.
// In an add, every cell compares its range with the new one at acceptance; then, with the
// output free, the chain merges, shifts, inserts or holds in one step and the result is
// loaded into the output register. A dump gives one beat per stored range, one per cycle
// while the output is taken, by rotating the chain through its head cell; an empty table
// gives a single beat with is_empty set. A new item is taken only when the previous one is
// finished, but a finished result may still wait at the output.
module interval_set_coalescing_insert_top (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_kind,
    input  logic [isci_pkg::KEY_W-1:0] s_begin_key,
    input  logic [isci_pkg::KEY_W-1:0] s_end_key,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [2:0]                 m_status,
    output logic [isci_pkg::KEY_W-1:0] m_range_start,
    output logic [isci_pkg::KEY_W-1:0] m_range_stop,
    output logic [isci_pkg::KEY_W-1:0] m_total_rows,
    output logic [isci_pkg::CNT_W-1:0] m_entry_count,
    output logic                       m_is_empty,
    output logic                       m_last_item
);

    localparam int N = isci_pkg::TABLE_ENTRIES;

    typedef enum logic [1:0] {S_IDLE, S_UPD, S_DUMP} state_t;

    state_t state_reg;
    logic [isci_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [isci_pkg::CNT_W-1:0] rem_reg;
    logic [isci_pkg::KEY_W-1:0] tot_reg, tot_next;
    logic [isci_pkg::KEY_W-1:0] b_reg, e_reg, len_reg;
    logic rev_reg, nil_reg;

    logic                       m_valid_reg;
    isci_pkg::status_t          m_status_reg;
    logic [isci_pkg::KEY_W-1:0] m_start_reg, m_stop_reg, m_total_reg;
    logic [isci_pkg::CNT_W-1:0] m_count_reg;
    logic                       m_empty_reg, m_last_reg;

    isci_pkg::op_t     op;
    isci_pkg::status_t st;
    logic              accept, out_free, upd_fire, dump_fire;
    logic              any_on, any_op, any_jr, any_jl;

    logic [N-1:0]     occ, le;
    isci_pkg::entry_t ents [N];
    isci_pkg::flag_t  flags [N];

    assign s_ready   = state_reg == S_IDLE;
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign upd_fire  = state_reg == S_UPD && out_free;
    assign dump_fire = state_reg == S_DUMP && out_free;

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_range_start = m_start_reg;
    assign m_range_stop  = m_stop_reg;
    assign m_total_rows  = m_total_reg;
    assign m_entry_count = m_count_reg;
    assign m_is_empty    = m_empty_reg;
    assign m_last_item   = m_last_reg;

    for (genvar i = 0; i < N; i++) begin : g_cell
        assign occ[i] = isci_pkg::CNT_W'(i) < cnt_reg;
        isci_cell u_cell (
            .aclk      (aclk),
            .cmp_en    (accept),
            .cmp_b     (s_begin_key),
            .cmp_e     (s_end_key),
            .upd_b     (b_reg),
            .upd_e     (e_reg),
            .op        (op),
            .occ       (occ[i]),
            .occ_next  ((i == N - 1) ? 1'b0 : occ[(i + 1) % N]),
            .le_prev   ((i == 0) ? 1'b1 : le[(i + N - 1) % N]),
            .le_next   ((i == N - 1) ? 1'b0 : le[(i + 1) % N]),
            .left_ent  (ents[(i + N - 1) % N]),
            .right_ent ((i == N - 1) ? ents[i] : ents[(i + 1) % N]),
            .head_ent  (ents[0]),
            .ent       (ents[i]),
            .le        (le[i]),
            .flags     (flags[i])
        );
    end

    always_comb begin
        any_on = 1'b0;
        any_op = 1'b0;
        any_jr = 1'b0;
        any_jl = 1'b0;
        for (int i = 0; i < N; i++) begin
            any_on = any_on | flags[i].over_next;
            any_op = any_op | flags[i].over_prev;
            any_jr = any_jr | flags[i].join_r;
            any_jl = any_jl | flags[i].join_l;
        end
    end

    always_comb begin
        op       = isci_pkg::OP_HOLD;
        st       = isci_pkg::ST_OK;
        cnt_next = cnt_reg;
        tot_next = tot_reg;
        if (upd_fire) begin
            if (rev_reg) begin
                st = isci_pkg::ST_REVERSED;
            end else if (nil_reg) begin
                st = isci_pkg::ST_OK;
            end else if (any_on) begin
                st = isci_pkg::ST_OVER_NEXT;
            end else if (any_op) begin
                st = isci_pkg::ST_OVER_PREV;
            end else if (any_jl && any_jr) begin
                op       = isci_pkg::OP_MERGE_BOTH;
                cnt_next = cnt_reg - isci_pkg::CNT_W'(1);
                tot_next = tot_reg + len_reg;
            end else if (any_jl) begin
                op       = isci_pkg::OP_MERGE_LEFT;
                tot_next = tot_reg + len_reg;
            end else if (any_jr) begin
                op       = isci_pkg::OP_MERGE_RIGHT;
                tot_next = tot_reg + len_reg;
            end else if (cnt_reg == isci_pkg::CNT_W'(N)) begin
                st = isci_pkg::ST_FULL;
            end else begin
                op       = isci_pkg::OP_INSERT;
                cnt_next = cnt_reg + isci_pkg::CNT_W'(1);
                tot_next = tot_reg + len_reg;
            end
        end else if (dump_fire && cnt_reg != '0) begin
            op = isci_pkg::OP_ROTATE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            tot_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            tot_reg <= tot_next;
            if (upd_fire || dump_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        state_reg <= s_kind ? S_DUMP : S_UPD;
                    end
                end
                S_UPD: begin
                    if (upd_fire) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_DUMP: begin
                    if (dump_fire) begin
                        if (cnt_reg == '0 || rem_reg == isci_pkg::CNT_W'(1)) begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (accept) begin
                b_reg   <= s_begin_key;
                e_reg   <= s_end_key;
                len_reg <= s_end_key - s_begin_key;
                rev_reg <= s_begin_key > s_end_key;
                nil_reg <= s_begin_key == s_end_key;
                rem_reg <= cnt_reg;
            end
            if (upd_fire) begin
                m_status_reg <= st;
                m_start_reg  <= '0;
                m_stop_reg   <= '0;
                m_total_reg  <= tot_next;
                m_count_reg  <= cnt_next;
                m_empty_reg  <= 1'b0;
                m_last_reg   <= 1'b1;
            end
            if (dump_fire) begin
                m_status_reg <= isci_pkg::ST_OK;
                m_total_reg  <= tot_reg;
                m_count_reg  <= cnt_reg;
                if (cnt_reg == '0) begin
                    m_start_reg <= '0;
                    m_stop_reg  <= '0;
                    m_empty_reg <= 1'b1;
                    m_last_reg  <= 1'b1;
                end else begin
                    m_start_reg <= ents[0].start;
                    m_stop_reg  <= ents[0].stop;
                    m_empty_reg <= 1'b0;
                    m_last_reg  <= rem_reg == isci_pkg::CNT_W'(1);
                    rem_reg     <= rem_reg - isci_pkg::CNT_W'(1);
                end
            end
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= isci_pkg::CNT_W'(N))
        else $error("entry count above table size");

    a_cnt_only_on_update: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && !$stable(cnt_reg)) |-> $past(upd_fire))
        else $error("entry count changed outside an add update");

    a_dump_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        dump_fire |=> m_valid_reg)
        else $error("dump cycle produced no beat");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (upd_fire || dump_fire) |-> !accept)
        else $error("item accepted while a previous one is in progress");

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the interval set coalescing insert block.
module tb_top;

    localparam int   KEY_W         = isci_pkg::KEY_W;
    localparam int   CNT_W         = isci_pkg::CNT_W;
    localparam int   TABLE_ENTRIES = isci_pkg::TABLE_ENTRIES;
    localparam logic KIND_ADD    = 1'b0;
    localparam logic KIND_DUMP   = 1'b1;
    localparam int   RANDOM_ITEMS = 300;
    localparam int   CYCLE_LIMIT  = 400000;
    localparam int   DRAIN_CYCLES = 16;
    localparam int   KEY_UNIT     = 16;
    localparam int   GRID_SLOTS   = 200;
    localparam logic [KEY_W-1:0] KEY_MAX = '1;

    typedef struct {
        logic [2:0]       status;
        logic [KEY_W-1:0] range_start;
        logic [KEY_W-1:0] range_stop;
        logic [KEY_W-1:0] total_rows;
        logic [CNT_W-1:0] entry_count;
        logic             is_empty;
        logic             last_item;
    } beat_t;

    class range_set_scoreboard;
        logic [KEY_W-1:0] starts [TABLE_ENTRIES];
        logic [KEY_W-1:0] stops  [TABLE_ENTRIES];
        int               used;
        logic [KEY_W-1:0] covered;
        beat_t            expected_beats [$];
        int               errors;

        function new();
            used    = 0;
            covered = '0;
            errors  = 0;
        endfunction

        function isci_pkg::status_t insert_range(logic [KEY_W-1:0] b, logic [KEY_W-1:0] e);
            int pos;
            bit join_r;
            bit join_l;
            pos    = 0;
            join_r = 0;
            join_l = 0;
            if (b > e) return isci_pkg::ST_REVERSED;
            if (b == e) return isci_pkg::ST_OK;
            while (pos < used && starts[pos] <= b) pos++;
            if (pos < used) begin
                if (e > starts[pos]) return isci_pkg::ST_OVER_NEXT;
                join_r = (e == starts[pos]);
            end
            if (pos > 0) begin
                if (stops[pos-1] > b) return isci_pkg::ST_OVER_PREV;
                join_l = (stops[pos-1] == b);
            end
            if (join_l && join_r) begin
                stops[pos-1] = stops[pos];
                for (int i = pos; i + 1 < used; i++) begin
                    starts[i] = starts[i+1];
                    stops[i]  = stops[i+1];
                end
                used--;
            end else if (join_l) begin
                stops[pos-1] = e;
            end else if (join_r) begin
                starts[pos] = b;
            end else begin
                if (used >= TABLE_ENTRIES) return isci_pkg::ST_FULL;
                for (int i = used; i > pos; i--) begin
                    starts[i] = starts[i-1];
                    stops[i]  = stops[i-1];
                end
                starts[pos] = b;
                stops[pos]  = e;
                used++;
            end
            covered += e - b;
            return isci_pkg::ST_OK;
        endfunction

        function void note_item(logic kind, logic [KEY_W-1:0] b, logic [KEY_W-1:0] e);
            beat_t bt;
            bt.status      = isci_pkg::ST_OK;
            bt.range_start = '0;
            bt.range_stop  = '0;
            bt.is_empty    = 1'b0;
            bt.last_item   = 1'b1;
            if (kind == KIND_ADD) begin
                bt.status      = insert_range(b, e);
                bt.total_rows  = covered;
                bt.entry_count = CNT_W'(used);
                expected_beats.push_back(bt);
            end else if (used == 0) begin
                bt.total_rows  = covered;
                bt.entry_count = CNT_W'(used);
                bt.is_empty    = 1'b1;
                expected_beats.push_back(bt);
            end else begin
                for (int i = 0; i < used; i++) begin
                    bt.range_start = starts[i];
                    bt.range_stop  = stops[i];
                    bt.total_rows  = covered;
                    bt.entry_count = CNT_W'(used);
                    bt.last_item   = (i + 1 == used);
                    expected_beats.push_back(bt);
                end
            end
        endfunction

        function void compare(string field, logic [KEY_W-1:0] exp_v, logic [KEY_W-1:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, field, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_beat(beat_t got);
            beat_t want;
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual start %0h stop %0h",
                         $time, got.range_start, got.range_stop);
                errors++;
                return;
            end
            want = expected_beats.pop_front();
            compare("status",      KEY_W'(want.status),      KEY_W'(got.status));
            compare("range_start", want.range_start,         got.range_start);
            compare("range_stop",  want.range_stop,          got.range_stop);
            compare("total_rows",  want.total_rows,          got.total_rows);
            compare("entry_count", KEY_W'(want.entry_count), KEY_W'(got.entry_count));
            compare("is_empty",    KEY_W'(want.is_empty),    KEY_W'(got.is_empty));
            compare("last_item",   KEY_W'(want.last_item),   KEY_W'(got.last_item));
        endfunction
    endclass

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic             s_kind;
    logic [KEY_W-1:0] s_begin_key;
    logic [KEY_W-1:0] s_end_key;
    logic             m_valid;
    logic             m_ready;
    logic [2:0]       m_status;
    logic [KEY_W-1:0] m_range_start;
    logic [KEY_W-1:0] m_range_stop;
    logic [KEY_W-1:0] m_total_rows;
    logic [CNT_W-1:0] m_entry_count;
    logic             m_is_empty;
    logic             m_last_item;

    range_set_scoreboard sb;
    int                  cycle_count;
    int                  burst_left;
    int                  ready_mode;
    int                  mode_cycles;
    logic [31:0]         ready_pattern;
    logic [KEY_W-1:0]    grid_base;

    interval_set_coalescing_insert_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_begin_key   (s_begin_key),
        .s_end_key     (s_end_key),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_range_start (m_range_start),
        .m_range_stop  (m_range_stop),
        .m_total_rows  (m_total_rows),
        .m_entry_count (m_entry_count),
        .m_is_empty    (m_is_empty),
        .m_last_item   (m_last_item)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: check taken beats, then pick next ready
    always @(posedge aclk) begin
        beat_t got;
        if (aresetn && m_valid && m_ready) begin
            got.status      = m_status;
            got.range_start = m_range_start;
            got.range_stop  = m_range_stop;
            got.total_rows  = m_total_rows;
            got.entry_count = m_entry_count;
            got.is_empty    = m_is_empty;
            got.last_item   = m_last_item;
            sb.check_beat(got);
        end
        if (mode_cycles == 0) begin
            ready_mode    = $urandom_range(0, 3);
            ready_pattern = $urandom;
            mode_cycles   = $urandom_range(20, 80);
        end
        mode_cycles--;
        ready_pattern = {ready_pattern[30:0], ready_pattern[31]};
        case (ready_mode)
            0: begin
                m_ready <= 1'b1;
            end
            1: begin
                m_ready <= 1'($urandom_range(0, 1));
            end
            2: begin
                m_ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                m_ready <= ready_pattern[0];
            end
        endcase
    end

    task automatic push_item(input logic kind, input logic [KEY_W-1:0] b,
                             input logic [KEY_W-1:0] e);
        int gap;
        s_valid     <= 1'b1;
        s_kind      <= kind;
        s_begin_key <= b;
        s_end_key   <= e;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_item(kind, b, e);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_beats.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [KEY_W-1:0] grid_key(int slot);
        return grid_base + KEY_W'(slot) * KEY_W'(KEY_UNIT);
    endfunction

    // mostly grid-aligned adds that abut, fill gaps or land fresh; some dumps and noise
    task automatic pick_item(output logic kind, output logic [KEY_W-1:0] b,
                             output logic [KEY_W-1:0] e);
        int pct;
        int idx;
        int len;
        pct  = $urandom_range(0, 99);
        len  = $urandom_range(1, 3);
        kind = KIND_ADD;
        b    = grid_key($urandom_range(0, GRID_SLOTS - 1));
        e    = b + KEY_W'(len * KEY_UNIT);
        if (pct < 10) begin
            kind = KIND_DUMP;
            b    = {$urandom, $urandom};
            e    = {$urandom, $urandom};
        end else if (pct < 18) begin
            b = {$urandom, $urandom};
            e = $urandom_range(0, 1) ? {$urandom, $urandom} : b + KEY_W'($urandom_range(1, 64));
        end else if (pct < 30 && sb.used > 0) begin
            idx = $urandom_range(0, sb.used - 1);
            b   = sb.stops[idx];
            e   = b + KEY_W'(len * KEY_UNIT);
        end else if (pct < 40 && sb.used > 0) begin
            idx = $urandom_range(0, sb.used - 1);
            e   = sb.starts[idx];
            b   = e - KEY_W'(len * KEY_UNIT);
        end else if (pct < 48 && sb.used > 1) begin
            idx = $urandom_range(0, sb.used - 2);
            b   = sb.stops[idx];
            e   = sb.starts[idx+1];
        end else if (pct < 52) begin
            e = $urandom_range(0, 1) ? b : b - KEY_W'($urandom_range(1, 64));
        end else if ($urandom_range(0, 3) == 0) begin
            b = b + KEY_W'($urandom_range(1, KEY_UNIT - 1));
            e = b + KEY_W'($urandom_range(1, 2 * KEY_UNIT));
        end
    endtask

    initial begin
        logic             kind;
        logic [KEY_W-1:0] b;
        logic [KEY_W-1:0] e;
        aclk          = 1'b0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_kind        = KIND_ADD;
        s_begin_key   = '0;
        s_end_key     = '0;
        m_ready       = 1'b0;
        cycle_count   = 0;
        burst_left    = 0;
        mode_cycles   = 0;
        ready_mode    = 0;
        ready_pattern = '0;
        grid_base     = {$urandom, $urandom} >> 1;
        sb            = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        push_item(KIND_DUMP, '0, '0);
        push_item(KIND_ADD, KEY_MAX, '0);
        push_item(KIND_ADD, KEY_MAX, KEY_MAX);
        push_item(KIND_ADD, '0, '0);
        push_item(KIND_ADD, 64'h0, 64'h10);
        push_item(KIND_ADD, KEY_MAX - 64'h10, KEY_MAX);
        push_item(KIND_ADD, 64'h10, 64'h20);
        push_item(KIND_ADD, 64'h30, 64'h40);
        push_item(KIND_ADD, 64'h28, 64'h30);
        push_item(KIND_ADD, 64'h20, 64'h28);
        push_item(KIND_ADD, 64'h38, 64'h50);
        push_item(KIND_ADD, 64'h50, KEY_MAX - 64'h8);
        push_item(KIND_ADD, 64'h0, 64'h4);
        push_item(KIND_ADD, 64'h100, 64'h200);
        push_item(KIND_ADD, 64'h80, 64'h180);
        push_item(KIND_DUMP, KEY_MAX, KEY_MAX);
        push_item(KIND_ADD, 64'h40, 64'h100);
        push_item(KIND_DUMP, '0, KEY_MAX);
        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) wait_drained();
            pick_item(kind, b, e);
            push_item(kind, b, e);
        end
        push_item(KIND_DUMP, '0, '0);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.errors == 0 && sb.expected_beats.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
